// ===== rtl/lav_pkg.sv =====
// shared types, constants and a helper function for the look-at view matrix block
// no dependencies
package lav_pkg;

  localparam int InFracBits  = 16;
  localparam int OutFracBits = 30;
  localparam int UnitBits    = 30;
  localparam int ElemW       = 48;

  typedef logic signed [31:0] unit_t;    // unit component, 30 fraction bits
  typedef logic signed [63:0] wide_t;

  // magnitude of a signed 64-bit value
  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    mag64 = v[63] ? (64'd0 - v) : v;
  endfunction

endpackage

// ===== rtl/lav_unitize.sv =====
// normalizes one 3-vector into signed unit components with 30 fraction bits
// depends on lav_pkg; pipelined: magnitudes and max, normalize shift, 31-step root, 31-step divides
module lav_unitize (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic signed [63:0]          vx_i,
  input  logic signed [63:0]          vy_i,
  input  logic signed [63:0]          vz_i,
  output logic                        valid_o,
  output lav_pkg::unit_t              ux_o,
  output lav_pkg::unit_t              uy_o,
  output lav_pkg::unit_t              uz_o,
  output logic                        zero_o
);
  import lav_pkg::*;

  localparam int RootSteps = 31;
  localparam int DivSteps  = 31;

  // stage 0: magnitudes and max
  logic [63:0] m_d [3];
  logic [63:0] mx_d;
  logic [63:0] m0_q [3];
  logic [63:0] mx0_q;
  logic [2:0]  sg0_q;
  logic        v0_q;

  always_comb begin
    for (int i = 0; i < 3; i++) m_d[i] = '0;
    m_d[0] = mag64(vx_i);
    m_d[1] = mag64(vy_i);
    m_d[2] = mag64(vz_i);
    mx_d = m_d[0];
    if (m_d[1] > mx_d) mx_d = m_d[1];
    if (m_d[2] > mx_d) mx_d = m_d[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    m0_q  <= m_d;
    mx0_q <= mx_d;
    sg0_q <= {vz_i[63], vy_i[63], vx_i[63]};
  end

  // stage 1: common shift so that max lands in [2^29, 2^30), then squares sum
  logic [6:0]  lz_d;
  logic [29:0] n_d [3];
  logic [61:0] s_d;
  logic [29:0] n1_q [3];
  logic [61:0] s1_q;
  logic [2:0]  sg1_q;
  logic        z1_q;
  logic        v1_q;

  always_comb begin
    lz_d = 7'd64;
    for (int b = 0; b < 64; b++) begin
      if (mx0_q[b]) lz_d = 7'(63 - b);
    end
    for (int i = 0; i < 3; i++) begin
      if (lz_d >= 7'd34) n_d[i] = 30'(m0_q[i] << (lz_d - 7'd34));
      else               n_d[i] = 30'(m0_q[i] >> (7'd34 - lz_d));
    end
    s_d = 62'(n_d[0]) * 62'(n_d[0]) + 62'(n_d[1]) * 62'(n_d[1])
        + 62'(n_d[2]) * 62'(n_d[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    n1_q  <= n_d;
    s1_q  <= s_d;
    sg1_q <= sg0_q;
    z1_q  <= (mx0_q == 64'd0);
  end

  // root stages: one result bit per stage
  logic [61:0] rs_q [RootSteps+1];
  logic [62:0] rr_q [RootSteps+1];
  logic [29:0] rn_q [RootSteps+1][3];
  logic [2:0]  rg_q [RootSteps+1];
  logic        rz_q [RootSteps+1];
  logic        rv_q [RootSteps+1];

  always_comb begin
    rs_q[0] = s1_q;
    rr_q[0] = '0;
    rn_q[0] = n1_q;
    rg_q[0] = sg1_q;
    rz_q[0] = z1_q;
    rv_q[0] = v1_q;
  end

  for (genvar k = 0; k < RootSteps; k++) begin : g_root
    localparam logic [62:0] Bit = 63'(1) << (2 * (RootSteps - 1 - k));
    logic [61:0] s_nx;
    logic [62:0] r_nx;
    always_comb begin
      if ({1'b0, rs_q[k]} >= rr_q[k] + Bit) begin
        s_nx = 62'({1'b0, rs_q[k]} - (rr_q[k] + Bit));
        r_nx = (rr_q[k] >> 1) + Bit;
      end else begin
        s_nx = rs_q[k];
        r_nx = rr_q[k] >> 1;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rv_q[k+1] <= 1'b0;
      end else begin
        rv_q[k+1] <= rv_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      rs_q[k+1] <= s_nx;
      rr_q[k+1] <= r_nx;
      rn_q[k+1] <= rn_q[k];
      rg_q[k+1] <= rg_q[k];
      rz_q[k+1] <= rz_q[k];
    end
  end

  // divide stages: num <= den, quotient bits of num*2^31/den, three lanes
  logic [31:0] len_w;
  assign len_w = 32'(rr_q[RootSteps]);

  logic [32:0] dr_q [DivSteps+1][3];
  logic [31:0] dq_q [DivSteps+1][3];
  logic [31:0] dl_q [DivSteps+1];
  logic [2:0]  dg_q [DivSteps+1];
  logic        dz_q [DivSteps+1];
  logic        dv_q [DivSteps+1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // integer quotient is 1 only when num equals den
      if (32'(rn_q[RootSteps][i]) >= len_w && len_w != 0) begin
        dr_q[0][i] = 33'(32'(rn_q[RootSteps][i]) - len_w);
        dq_q[0][i] = 32'd1;
      end else begin
        dr_q[0][i] = 33'(rn_q[RootSteps][i]);
        dq_q[0][i] = 32'd0;
      end
    end
    dl_q[0] = len_w;
    dg_q[0] = rg_q[RootSteps];
    dz_q[0] = rz_q[RootSteps];
    dv_q[0] = rv_q[RootSteps];
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    logic [32:0] r_nx [3];
    logic [31:0] q_nx [3];
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        if ((dr_q[k][i] << 1) >= {1'b0, dl_q[k]}) begin
          r_nx[i] = (dr_q[k][i] << 1) - {1'b0, dl_q[k]};
          q_nx[i] = {dq_q[k][i][30:0], 1'b1};
        end else begin
          r_nx[i] = dr_q[k][i] << 1;
          q_nx[i] = {dq_q[k][i][30:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else begin
        dv_q[k+1] <= dv_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      dr_q[k+1] <= r_nx;
      dq_q[k+1] <= q_nx;
      dl_q[k+1] <= dl_q[k];
      dg_q[k+1] <= dg_q[k];
      dz_q[k+1] <= dz_q[k];
    end
  end

  // round half up, apply sign
  logic [31:0] rq [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rq[i] = 32'((33'(dq_q[DivSteps][i]) + 33'd1) >> 1);
    end
  end

  assign valid_o = dv_q[DivSteps];
  assign zero_o  = dz_q[DivSteps];
  assign ux_o = dz_q[DivSteps] ? '0 : (dg_q[DivSteps][0] ? -$signed(rq[0]) : $signed(rq[0]));
  assign uy_o = dz_q[DivSteps] ? '0 : (dg_q[DivSteps][1] ? -$signed(rq[1]) : $signed(rq[1]));
  assign uz_o = dz_q[DivSteps] ? '0 : (dg_q[DivSteps][2] ? -$signed(rq[2]) : $signed(rq[2]));
endmodule

// ===== rtl/look_at_view_matrix_top.sv =====
// look-at view matrix top level: three chained normalizer pipelines, cross
// products, translation dot products and a four-row output sequencer; uses lav_pkg
// An item is taken when start is high and busy low; busy then stays high while a gap
// counter runs down, spacing items to match the four rows each item yields. Rows come
// out one per cycle, strobed by row_valid_o, and must be taken as shown since the
// receiver cannot stall. Row 0 of an item passes the input register, the three chained
// 64-stage normalizers (square root and divide are one bit a stage), a product register
// after each of the first two, and the translation, rescale and sequencer registers.
module look_at_view_matrix_top #(
  parameter int IN_FRAC_BITS  = lav_pkg::InFracBits,
  parameter int OUT_FRAC_BITS = lav_pkg::OutFracBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] eye_x_i,
  input  logic signed [31:0] eye_y_i,
  input  logic signed [31:0] eye_z_i,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  input  logic signed [31:0] target_z_i,
  input  logic signed [31:0] upvec_x_i,
  input  logic signed [31:0] upvec_y_i,
  input  logic signed [31:0] upvec_z_i,
  output logic               row_valid_o,
  output logic [1:0]         row_index_o,
  output logic signed [47:0] elem_0_o,
  output logic signed [47:0] elem_1_o,
  output logic signed [47:0] elem_2_o,
  output logic               elem_3_o,
  output logic               degenerate_o,
  output logic               last_row_o
);
  import lav_pkg::*;

  localparam int UnitLat = 2 + 31 + 31; // normalizer latency
  localparam int TrSh    = UnitBits + IN_FRAC_BITS - OUT_FRAC_BITS;
  localparam int UnSh    = UnitBits - OUT_FRAC_BITS;

  // issue spacing: busy holds off a new item while the gap counter runs down
  logic [1:0] gap_q;
  logic       acc;
  assign busy = (gap_q != 2'd0);
  assign acc  = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= '0;
    end else if (acc) begin
      gap_q <= 2'd3;
    end else if (gap_q != 2'd0) begin
      gap_q <= gap_q - 2'd1;
    end
  end

  // input register and direction
  logic               v_in_q;
  logic signed [63:0] dir_q [3];
  logic signed [31:0] eye_in_q [3];
  logic signed [31:0] upv_in_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_in_q <= 1'b0;
    end else begin
      v_in_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    dir_q[0] <= 64'(target_x_i) - 64'(eye_x_i);
    dir_q[1] <= 64'(target_y_i) - 64'(eye_y_i);
    dir_q[2] <= 64'(target_z_i) - 64'(eye_z_i);
    eye_in_q <= '{eye_x_i, eye_y_i, eye_z_i};
    upv_in_q <= '{upvec_x_i, upvec_y_i, upvec_z_i};
  end

  // eye and up vector delay lines beside the first normalizer
  logic signed [31:0] eye_dl_q [UnitLat+1][3];
  logic signed [31:0] upv_dl_q [UnitLat+1][3];
  always_comb begin
    eye_dl_q[0] = eye_in_q;
    upv_dl_q[0] = upv_in_q;
  end
  for (genvar k = 0; k < UnitLat; k++) begin : g_dl1
    always_ff @(posedge clk_i) begin
      eye_dl_q[k+1] <= eye_dl_q[k];
      upv_dl_q[k+1] <= upv_dl_q[k];
    end
  end

  // forward axis
  logic  fv, fz;
  unit_t f [3];
  lav_unitize u_fwd (
    .clk_i, .rst_ni, .valid_i(v_in_q),
    .vx_i(dir_q[0]), .vy_i(dir_q[1]), .vz_i(dir_q[2]),
    .valid_o(fv), .ux_o(f[0]), .uy_o(f[1]), .uz_o(f[2]), .zero_o(fz)
  );

  // cross(forward, up): products registered, then differences
  logic signed [63:0] p1_q [6];
  logic               p1v_q, p1z_q;
  unit_t              f1_q [3];
  logic signed [31:0] e1_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p1v_q <= 1'b0;
    else         p1v_q <= fv;
  end
  always_ff @(posedge clk_i) begin
    p1_q[0] <= f[1] * upv_dl_q[UnitLat][2];
    p1_q[1] <= f[2] * upv_dl_q[UnitLat][1];
    p1_q[2] <= f[2] * upv_dl_q[UnitLat][0];
    p1_q[3] <= f[0] * upv_dl_q[UnitLat][2];
    p1_q[4] <= f[0] * upv_dl_q[UnitLat][1];
    p1_q[5] <= f[1] * upv_dl_q[UnitLat][0];
    p1z_q   <= fz;
    f1_q    <= f;
    e1_q    <= eye_dl_q[UnitLat];
  end

  logic signed [63:0] c1 [3];
  assign c1[0] = p1_q[0] - p1_q[1];
  assign c1[1] = p1_q[2] - p1_q[3];
  assign c1[2] = p1_q[4] - p1_q[5];

  // forward, eye and flag delay beside the side normalizer
  unit_t              f_dl_q [UnitLat+1][3];
  logic signed [31:0] e2_dl_q [UnitLat+1][3];
  logic               z_dl_q [UnitLat+1];
  always_comb begin
    f_dl_q[0]  = f1_q;
    e2_dl_q[0] = e1_q;
    z_dl_q[0]  = p1z_q;
  end
  for (genvar k = 0; k < UnitLat; k++) begin : g_dl2
    always_ff @(posedge clk_i) begin
      f_dl_q[k+1]  <= f_dl_q[k];
      e2_dl_q[k+1] <= e2_dl_q[k];
      z_dl_q[k+1]  <= z_dl_q[k];
    end
  end

  logic  sv, sz;
  unit_t s [3];
  lav_unitize u_side (
    .clk_i, .rst_ni, .valid_i(p1v_q),
    .vx_i(c1[0]), .vy_i(c1[1]), .vz_i(c1[2]),
    .valid_o(sv), .ux_o(s[0]), .uy_o(s[1]), .uz_o(s[2]), .zero_o(sz)
  );

  // cross(side, forward)
  logic signed [63:0] p2_q [6];
  logic               p2v_q, p2z_q;
  unit_t              f2_q [3], s2_q [3];
  logic signed [31:0] e3_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p2v_q <= 1'b0;
    else         p2v_q <= sv;
  end
  always_ff @(posedge clk_i) begin
    p2_q[0] <= s[1] * f_dl_q[UnitLat][2];
    p2_q[1] <= s[2] * f_dl_q[UnitLat][1];
    p2_q[2] <= s[2] * f_dl_q[UnitLat][0];
    p2_q[3] <= s[0] * f_dl_q[UnitLat][2];
    p2_q[4] <= s[0] * f_dl_q[UnitLat][1];
    p2_q[5] <= s[1] * f_dl_q[UnitLat][0];
    p2z_q   <= sz || z_dl_q[UnitLat];
    f2_q    <= f_dl_q[UnitLat];
    s2_q    <= s;
    e3_q    <= e2_dl_q[UnitLat];
  end

  logic signed [63:0] c2 [3];
  assign c2[0] = p2_q[0] - p2_q[1];
  assign c2[1] = p2_q[2] - p2_q[3];
  assign c2[2] = p2_q[4] - p2_q[5];

  unit_t              f3_dl_q [UnitLat+1][3], s3_dl_q [UnitLat+1][3];
  logic signed [31:0] e4_dl_q [UnitLat+1][3];
  logic               z3_dl_q [UnitLat+1];
  always_comb begin
    f3_dl_q[0] = f2_q;
    s3_dl_q[0] = s2_q;
    e4_dl_q[0] = e3_q;
    z3_dl_q[0] = p2z_q;
  end
  for (genvar k = 0; k < UnitLat; k++) begin : g_dl3
    always_ff @(posedge clk_i) begin
      f3_dl_q[k+1] <= f3_dl_q[k];
      s3_dl_q[k+1] <= s3_dl_q[k];
      e4_dl_q[k+1] <= e4_dl_q[k];
      z3_dl_q[k+1] <= z3_dl_q[k];
    end
  end

  logic  uv, uz;
  unit_t ua [3];
  lav_unitize u_up (
    .clk_i, .rst_ni, .valid_i(p2v_q),
    .vx_i(c2[0]), .vy_i(c2[1]), .vz_i(c2[2]),
    .valid_o(uv), .ux_o(ua[0]), .uy_o(ua[1]), .uz_o(ua[2]), .zero_o(uz)
  );

  // translation: nine products, then sums
  logic signed [63:0] tp_q [3][3];
  unit_t              fa_q [3], sa_q [3], ub_q [3];
  logic               tv_q, tz_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tv_q <= 1'b0;
    else         tv_q <= uv;
  end
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      tp_q[0][i] <= s3_dl_q[UnitLat][i] * e4_dl_q[UnitLat][i];
      tp_q[1][i] <= ua[i] * e4_dl_q[UnitLat][i];
      tp_q[2][i] <= f3_dl_q[UnitLat][i] * e4_dl_q[UnitLat][i];
    end
    fa_q <= f3_dl_q[UnitLat];
    sa_q <= s3_dl_q[UnitLat];
    ub_q <= ua;
    tz_q <= uz || z3_dl_q[UnitLat];
  end

  // sums in 66 bits, then rescale
  function automatic logic signed [47:0] resc(input logic signed [65:0] v, input int sh);
    logic [65:0] mag;
    logic [65:0] lim;
    logic [65:0] r;
    begin
      mag = v[65] ? (66'd0 - v) : v;
      lim = v[65] ? (66'd1 << 47) : ((66'd1 << 47) - 66'd1);
      r = mag;
      if (sh > 0) r = (mag + (66'd1 << (sh - 1))) >> sh;
      else if (sh < 0) r = (mag > (lim >> (-sh))) ? lim : (mag << (-sh));
      if (r > lim) r = lim;
      resc = v[65] ? 48'(66'd0 - r) : 48'(r);
    end
  endfunction

  logic signed [47:0] row_q [4][3];
  logic               ov_q, oz_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else         ov_q <= tv_q;
  end
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      row_q[r][0] <= resc(66'(sa_q[r]), UnSh);
      row_q[r][1] <= resc(66'(ub_q[r]), UnSh);
      row_q[r][2] <= resc(66'(fa_q[r]), UnSh);
    end
    for (int a = 0; a < 3; a++) begin
      row_q[3][a] <= resc(-(66'(tp_q[a][0]) + 66'(tp_q[a][1]) + 66'(tp_q[a][2])), TrSh);
    end
    oz_q <= tz_q;
  end

  // row sequencer: holds one matrix while its four rows go out
  logic signed [47:0] hold_q [4][3];
  logic               hz_q;
  logic [1:0]         rc_q;
  logic               act_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      rc_q  <= '0;
    end else if (ov_q) begin
      act_q <= 1'b1;
      rc_q  <= '0;
    end else if (act_q) begin
      rc_q  <= rc_q + 2'd1;
      act_q <= (rc_q != 2'd3);
    end
  end
  always_ff @(posedge clk_i) begin
    if (ov_q) begin
      hold_q <= row_q;
      hz_q   <= oz_q;
    end
  end

  assign row_valid_o  = act_q;
  assign row_index_o  = rc_q;
  assign elem_0_o     = hz_q ? '0 : hold_q[rc_q][0];
  assign elem_1_o     = hz_q ? '0 : hold_q[rc_q][1];
  assign elem_2_o     = hz_q ? '0 : hold_q[rc_q][2];
  assign elem_3_o     = (rc_q == 2'd3);
  assign degenerate_o = hz_q;
  assign last_row_o   = (rc_q == 2'd3);
endmodule

// ===== rtl/lav_checker.sv =====
// port-level checker for the look-at view matrix top level, bound below
// depends on nothing but the top level's ports
module lav_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       row_valid_o,
  input logic [1:0] row_index_o,
  input logic       last_row_o,
  input logic       elem_3_o
);
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("busy low after item taken");
  a_row_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_valid_o && row_index_o != 2'd3 |=> row_valid_o &&
      row_index_o == $past(row_index_o) + 2'd1) else $error("row sequence broken");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_valid_o |-> (last_row_o == (row_index_o == 2'd3)) && (elem_3_o == last_row_o))
    else $error("last row flags wrong");
endmodule

bind look_at_view_matrix_top lav_checker u_lav_checker (
  .clk_i, .rst_ni, .start, .busy, .row_valid_o, .row_index_o, .last_row_o, .elem_3_o
);

// ===== tb/tb.sv =====
// testbench for look_at_view_matrix_top: random and directed camera items,
// a local predictor of the four view-matrix rows, and an in-order row checker; uses lav_pkg
`timescale 1ns / 1ps

module tb;
  import lav_pkg::*;

  localparam int LatencyCycles = 260;
  localparam longint CycleLimit = 400000;

  typedef struct packed {
    logic [1:0]         row;
    logic signed [47:0] e0;
    logic signed [47:0] e1;
    logic signed [47:0] e2;
    logic               e3;
    logic               degen;
    logic               last;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] eye_x_i = '0, eye_y_i = '0, eye_z_i = '0;
  logic signed [31:0] target_x_i = '0, target_y_i = '0, target_z_i = '0;
  logic signed [31:0] upvec_x_i = '0, upvec_y_i = '0, upvec_z_i = '0;
  logic row_valid_o;
  logic [1:0] row_index_o;
  logic signed [47:0] elem_0_o, elem_1_o, elem_2_o;
  logic elem_3_o, degenerate_o, last_row_o;

  row_t pending_rows[$];
  int errors = 0;
  longint cycles = 0;

  look_at_view_matrix_top uut (
    .clk_i, .rst_ni, .start, .busy,
    .eye_x_i, .eye_y_i, .eye_z_i,
    .target_x_i, .target_y_i, .target_z_i,
    .upvec_x_i, .upvec_y_i, .upvec_z_i,
    .row_valid_o, .row_index_o, .elem_0_o, .elem_1_o, .elem_2_o,
    .elem_3_o, .degenerate_o, .last_row_o
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [63:0] mag_of(input logic signed [63:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] s);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // round(num * 2^30 / den), half up
  function automatic logic [63:0] unit_div(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q, rem;
    q = num / den;
    rem = num % den;
    for (int i = 0; i <= UnitBits; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q[0] = 1'b1;
      end
    end
    return (q + 1) >> 1;
  endfunction

  function automatic bit normalize(input logic signed [63:0] v[3],
                                   output logic signed [63:0] u[3]);
    logic [63:0] m[3];
    logic [63:0] mx, s, len, q;
    mx = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag_of(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return 0;
    end
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      mx = mx >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      mx = mx << 1;
    end
    for (int i = 0; i < 3; i++) s = s + m[i] * m[i];
    len = int_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = unit_div(m[i], len);
      u[i] = v[i] < 0 ? -$signed(q) : $signed(q);
    end
    return 1;
  endfunction

  function automatic void cross_prod(input logic signed [63:0] a[3],
                                     input logic signed [63:0] b[3],
                                     output logic signed [63:0] r[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  // shift right (or left for a negative shift) with round half away from zero, saturate to 48 bits
  function automatic logic signed [47:0] to_q30(input logic signed [63:0] v, input int sh);
    logic [63:0] mg, lim;
    mg = mag_of(v);
    lim = v < 0 ? (64'd1 << 47) : (64'd1 << 47) - 1;
    if (sh > 0) mg = (mg + (64'd1 << (sh - 1))) >> sh;
    else if (sh < 0) mg = (mg > (lim >> (-sh))) ? lim : mg << (-sh);
    if (mg > lim) mg = lim;
    return v < 0 ? 48'(-$signed(mg)) : 48'($signed(mg));
  endfunction

  task automatic predict_view_rows(input logic signed [31:0] cam[9]);
    logic signed [63:0] eye[3], dir[3], upv[3], fwd[3], side[3], upa[3], tmp[3], tr[3];
    logic signed [63:0] src[3];
    bit ok;
    row_t r;
    for (int i = 0; i < 3; i++) begin
      eye[i] = cam[i];
      dir[i] = 64'(cam[3 + i]) - eye[i];
      upv[i] = cam[6 + i];
    end
    ok = normalize(dir, fwd);
    cross_prod(fwd, upv, tmp);
    ok = normalize(tmp, side) && ok;
    cross_prod(side, fwd, tmp);
    ok = normalize(tmp, upa) && ok;
    tr[0] = -(side[0] * eye[0] + side[1] * eye[1] + side[2] * eye[2]);
    tr[1] = -(upa[0] * eye[0] + upa[1] * eye[1] + upa[2] * eye[2]);
    tr[2] = -(fwd[0] * eye[0] + fwd[1] * eye[1] + fwd[2] * eye[2]);
    for (int k = 0; k < 4; k++) begin
      int sh;
      if (k < 3) begin
        src[0] = side[k];
        src[1] = upa[k];
        src[2] = fwd[k];
        sh = UnitBits - OutFracBits;
      end else begin
        src = tr;
        sh = UnitBits + InFracBits - OutFracBits;
      end
      r.row = k[1:0];
      r.e0 = ok ? to_q30(src[0], sh) : '0;
      r.e1 = ok ? to_q30(src[1], sh) : '0;
      r.e2 = ok ? to_q30(src[2], sh) : '0;
      r.e3 = (k == 3);
      r.degen = !ok;
      r.last = (k == 3);
      pending_rows.push_back(r);
    end
  endtask

  // row checker
  always @(posedge clk_i) begin
    if (rst_ni && row_valid_o) begin
      if (pending_rows.size() == 0) begin
        $error("unexpected row %0d", row_index_o);
        errors++;
      end else begin
        row_t x;
        x = pending_rows.pop_front();
        if (row_index_o !== x.row) begin
          $error("row_index exp %0d got %0d", x.row, row_index_o); errors++;
        end
        if (elem_0_o !== x.e0) begin
          $error("elem_0 exp %0d got %0d", x.e0, elem_0_o); errors++;
        end
        if (elem_1_o !== x.e1) begin
          $error("elem_1 exp %0d got %0d", x.e1, elem_1_o); errors++;
        end
        if (elem_2_o !== x.e2) begin
          $error("elem_2 exp %0d got %0d", x.e2, elem_2_o); errors++;
        end
        if (elem_3_o !== x.e3) begin
          $error("elem_3 exp %0d got %0d", x.e3, elem_3_o); errors++;
        end
        if (degenerate_o !== x.degen) begin
          $error("degenerate exp %0d got %0d", x.degen, degenerate_o); errors++;
        end
        if (last_row_o !== x.last) begin
          $error("last_row exp %0d got %0d", x.last, last_row_o); errors++;
        end
      end
    end
  end

  // send one camera item, with a random gap before it when gaps is set
  task automatic send_camera(input logic signed [31:0] cam[9], input bit gaps = 1);
    int gap;
    gap = gaps ? $urandom_range(0, 3) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    {eye_x_i, eye_y_i, eye_z_i} <= {cam[0], cam[1], cam[2]};
    {target_x_i, target_y_i, target_z_i} <= {cam[3], cam[4], cam[5]};
    {upvec_x_i, upvec_y_i, upvec_z_i} <= {cam[6], cam[7], cam[8]};
    start <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    predict_view_rows(cam);
  endtask

  task automatic release_start();
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_coord(input int mode);
    case (mode)
      0: return $urandom();
      1: return $signed(32'($urandom_range(0, 20))) - 10;
      2: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
      default: return $signed($urandom_range(0, 32'h0fffffff)) - 32'sh08000000;
    endcase
  endfunction

  task automatic test_directed();
    logic signed [31:0] c[9];
    logic signed [31:0] mx, mn, one;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    one = 32'sh00010000;
    c = '{0, 0, 0, 0, 0, -one, 0, one, 0}; send_camera(c);      // plain camera
    c = '{one, 2 * one, 3 * one, one, 2 * one, 3 * one, 0, one, 0}; send_camera(c); // eye on target
    c = '{0, 0, 0, 0, one, 0, 0, one, 0}; send_camera(c);       // up parallel to forward
    c = '{0, 0, 0, one, 0, 0, 0, 0, 0}; send_camera(c);         // zero up vector
    c = '{mx, mx, mx, mn, mn, mn, 0, one, 0}; send_camera(c);   // widest direction
    c = '{mn, mn, mn, mx, mx, mx, mx, mn, mx}; send_camera(c);
    c = '{mx, mn, mx, 0, 0, 0, mn, mx, mn}; send_camera(c);     // extreme eye position
    c = '{mn, mx, mn, 0, 0, 0, 0, 0, mx}; send_camera(c);
    c = '{0, 0, 0, 1, 0, 0, 0, 1, 0}; send_camera(c);           // smallest vectors
    c = '{-1, -1, -1, 0, 0, 0, 1, 0, 0}; send_camera(c);
    c = '{32'shffffffff, 0, 0, 32'sh55555555, 32'shaaaaaaaa, 3, 0, 0, 32'shfffffff0}; send_camera(c);
    c = '{mx, 0, 0, mx, 0, 0, mx, mx, mx}; send_camera(c);
    release_start();
  endtask

  task automatic test_random(input int n);
    logic signed [31:0] c[9];
    int mode;
    for (int k = 0; k < n; k++) begin
      mode = $urandom_range(0, 3);
      for (int i = 0; i < 9; i++) c[i] = rand_coord(mode);
      // occasionally force a degenerate case
      case ($urandom_range(0, 15))
        0: for (int i = 0; i < 3; i++) c[3 + i] = c[i];
        1: for (int i = 0; i < 3; i++) c[6 + i] = 0;
        default: ;
      endcase
      // runs of back-to-back items
      send_camera(c, (k % 40) >= 15);
    end
    release_start();
  endtask

  task automatic wait_drained();
    while (pending_rows.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    wait_drained();
    test_random(130);
    wait_drained();
    test_random(140);
    wait_drained();
    repeat (LatencyCycles) @(posedge clk_i);
    if (errors == 0 && pending_rows.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
